@@ rtl/tkps_pkg.sv @@
`default_nettype none
package tkps_pkg;
	localparam int CAPACITY  = 64;
	localparam int NODE_BITS = 20;
	localparam int SCORE_W   = 16;
	localparam int KEEP_W    = 7;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [NODE_BITS-1:0]      src;
		logic [NODE_BITS-1:0]      tgt;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic ins;
		logic pop;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_zero;
		logic out_valid;
	} status_t;
endpackage
`default_nettype wire

@@ rtl/top_k_pair_similarity_select.sv @@
// Top-k selector for scored node pairs.
// Input channel (in_valid/in_ready): command, score (signed Q1.15), source_node,
// target_node. An insert transfer is absorbed in the cycle it is taken; inserts
// can follow each other every cycle while idle. Output channel (out_valid/out_ready):
// out_score, out_source, out_target, last_item, one transfer per held entry.
// Entries sit in a sorted chain of registers, highest score first; each insert
// compares against every cell in parallel and shifts the lower cells down by one.
// A drain transfer sends the controller into its drain state, which then moves
// one entry per cycle into the output register, highest score first, whenever
// the output register is free. Input is not accepted until the chain is empty
// and the controller is back in idle.
// A stalled receiver holds the output register and the drain simply waits; the
// last entry may still sit in the output register while new inserts are accepted.
// cfg_write_en/cfg_write_data set keep_count; write it only while idle.
// Reset empties the chain and sets keep_count to 64; no clearing pass is needed.
`default_nettype none
module top_k_pair_similarity_select (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write_en,
	input  wire logic [tkps_pkg::KEEP_W-1:0]            cfg_write_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   command,
	input  wire logic signed [tkps_pkg::SCORE_W-1:0]    score,
	input  wire logic [tkps_pkg::NODE_BITS-1:0]         source_node,
	input  wire logic [tkps_pkg::NODE_BITS-1:0]         target_node,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [tkps_pkg::SCORE_W-1:0]         out_score,
	output logic [tkps_pkg::NODE_BITS-1:0]              out_source,
	output logic [tkps_pkg::NODE_BITS-1:0]              out_target,
	output logic                                        last_item
);
	import tkps_pkg::*;

	cmd_t    cmd;
	status_t status;

	tkps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tkps_chain u_chain (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.score         (score),
		.source_node   (source_node),
		.target_node   (target_node),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_score     (out_score),
		.out_source    (out_source),
		.out_target    (out_target),
		.last_item     (last_item)
	);
endmodule
`default_nettype wire

@@ rtl/tkps_chain.sv @@
`default_nettype none
module tkps_chain (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire tkps_pkg::cmd_t                         cmd,
	output tkps_pkg::status_t                           status,
	input  wire logic                                   cfg_write_en,
	input  wire logic [tkps_pkg::KEEP_W-1:0]            cfg_write_data,
	input  wire logic signed [tkps_pkg::SCORE_W-1:0]    score,
	input  wire logic [tkps_pkg::NODE_BITS-1:0]         source_node,
	input  wire logic [tkps_pkg::NODE_BITS-1:0]         target_node,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic signed [tkps_pkg::SCORE_W-1:0]         out_score,
	output logic [tkps_pkg::NODE_BITS-1:0]              out_source,
	output logic [tkps_pkg::NODE_BITS-1:0]              out_target,
	output logic                                        last_item
);
	import tkps_pkg::*;

	entry_t              cell_q [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	logic [KEEP_W-1:0]   keep_count_q;
	logic [KEEP_W-1:0]   k_eff;
	logic [CAPACITY-1:0] ge;
	logic                any_lt;
	logic                room;
	logic                take;
	entry_t              new_entry;
	entry_t              out_q;
	logic                out_valid_q;
	logic                last_q;

	assign new_entry = '{score: score, src: source_node, tgt: target_node};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_W'(CAPACITY);
		end else if (cfg_write_en) begin
			keep_count_q <= cfg_write_data;
		end
	end

	always_comb begin
		if (keep_count_q == '0) begin
			k_eff = KEEP_W'(1);
		end else if (keep_count_q > KEEP_W'(CAPACITY)) begin
			k_eff = KEEP_W'(CAPACITY);
		end else begin
			k_eff = keep_count_q;
		end
	end

	// held entries scoring at least the new one; sorted order makes this a prefix
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		assign ge[i] = (CNT_W'(i) < count_q) && (cell_q[i].score >= score);
	end

	// some held entry scores below the new one, so the minimum is strictly lower
	assign any_lt = |(~ge & ((CAPACITY)'(1) << count_q) - (CAPACITY)'(1));
	assign room   = KEEP_W'(count_q) < k_eff;
	assign take   = cmd.ins && (room || any_lt);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (take && !ge[i]) begin
				if (i == 0) begin
					cell_q[i] <= new_entry;
				end else if (ge[(i == 0) ? 0 : i-1]) begin
					cell_q[i] <= new_entry;
				end else begin
					cell_q[i] <= cell_q[(i == 0) ? 0 : i-1];
				end
			end else if (cmd.pop && i < CAPACITY-1) begin
				cell_q[i] <= cell_q[(i < CAPACITY-1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take && room) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_q  <= cell_q[0];
			last_q <= (count_q == CNT_W'(1));
		end
	end

	assign status.count_zero = (count_q == '0);
	assign status.out_valid  = out_valid_q;

	assign out_valid  = out_valid_q;
	assign out_score  = out_q.score;
	assign out_source = out_q.src;
	assign out_target = out_q.tgt;
	assign last_item  = last_q;
endmodule
`default_nettype wire

@@ rtl/tkps_ctrl.sv @@
`default_nettype none
module tkps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              command,
	input  wire logic              out_ready,
	input  wire tkps_pkg::status_t status,
	output tkps_pkg::cmd_t         cmd
);
	import tkps_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (command == CMD_DRAIN) begin
						state_d = ST_DRAIN;
					end else begin
						cmd.ins = 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				// advance one entry whenever the output register frees up
				if (status.count_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.pop = !status.out_valid || out_ready;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire
